// File: hdl/pch_pkg.sv
package pch_pkg;

   // Field widths fixed by the item format
   localparam int SAMPLE_BITS    = 8;
   localparam int BIN_ADDR_BITS  = 8;
   localparam int BIN_TOTAL      = 256;
   localparam int CHAN_BITS      = 2;
   localparam int CFG_BITS       = 3;
   localparam int COUNT_OUT_BITS = 22;
   localparam logic [COUNT_OUT_BITS-1:0] COUNT_OUT_MAX = 22'h3FFFFF;
   localparam logic [CFG_BITS-1:0]       CHANNELS_RESET = 3'd1;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_COUNT = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } pch_op_type;

   // Per-lane control from the sequencer
   typedef struct packed {
      logic                     load;
      logic                     inc;
      logic                     clr;
      logic [BIN_ADDR_BITS-1:0] clr_addr;
   } pch_lane_ctl_type;

endpackage

// File: hdl/per_channel_histogram_core.sv
// Per-channel 256-bin histogram. Each colour channel has its own lane with a
// 256-entry count memory; a count beat updates all channels in use at once.
// A count beat does a registered memory read, then a saturating write; a read
// beat does a registered memory read, then any wait on the result register; an
// unused opcode leaves the sequencer idle. A clear beat sweeps the bins one
// address per cycle in every lane at once. After reset the same sweep runs
// before the first request beat is taken; csr writes are taken at any time.
// Counts saturate at 2^COUNT_BITS-1 and read back capped at 22 bits.
module per_channel_histogram_core import pch_pkg::*; #(
   parameter int MAX_CHANNELS = 4,
   parameter int COUNT_BITS   = 22
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [SAMPLE_BITS-1:0]    req_sample_zero,
   input  logic [SAMPLE_BITS-1:0]    req_sample_one,
   input  logic [SAMPLE_BITS-1:0]    req_sample_two,
   input  logic [SAMPLE_BITS-1:0]    req_sample_three,
   input  logic [CHAN_BITS-1:0]      req_read_channel,
   input  logic [BIN_ADDR_BITS-1:0]  req_read_bin,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COUNT_OUT_BITS-1:0] rsp_bin_count,
   output logic [CHAN_BITS-1:0]      rsp_count_channel,
   output logic [BIN_ADDR_BITS-1:0]  rsp_count_bin,
   input  logic                      csr_wr_en,
   input  logic [CFG_BITS-1:0]       csr_wr_data
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_REPLY  = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [BIN_ADDR_BITS-1:0] cursor_ff, cursor_in;
   logic [CFG_BITS-1:0]      used_ff;
   logic [CHAN_BITS-1:0]     chan_ff;
   logic [BIN_ADDR_BITS-1:0] bin_ff;
   logic                     accept;
   pch_op_type               op;
   logic                     merge_free;
   logic                     merge_load;
   logic [SAMPLE_BITS-1:0]   sample_arr [4];
   logic [COUNT_BITS-1:0]    lane_count [MAX_CHANNELS];

   assign op        = pch_op_type'(req_opcode);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign sample_arr[0] = req_sample_zero;
   assign sample_arr[1] = req_sample_one;
   assign sample_arr[2] = req_sample_two;
   assign sample_arr[3] = req_sample_three;

   // Channel count register
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= CHANNELS_RESET;
      end else if (csr_wr_en) begin
         used_ff <= csr_wr_data;
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cursor_in = cursor_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cursor_in = cursor_ff + 1'b1;
            if (cursor_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_COUNT: state_in = ST_UPDATE;
                  OP_READ:  state_in = ST_REPLY;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_NONE:  state_in = ST_IDLE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         ST_REPLY: begin
            if (merge_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
      end
   end

   // Hold the read target for the reply
   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff <= req_read_channel;
         bin_ff  <= req_read_bin;
      end
   end

   // One lane per channel
   for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
      pch_lane_ctl_type         ctl;
      logic [BIN_ADDR_BITS-1:0] lane_addr;

      assign lane_addr    = (op == OP_READ) ? req_read_bin : sample_arr[c];
      assign ctl.load     = accept;
      assign ctl.inc      = (state_ff == ST_UPDATE) && (CFG_BITS'(c) < used_ff);
      assign ctl.clr      = (state_ff == ST_CLEAR);
      assign ctl.clr_addr = cursor_ff;

      pch_lane #(
         .COUNT_BITS(COUNT_BITS)
      ) u_lane (
         .clock(clock),
         .ctl  (ctl),
         .addr (lane_addr),
         .count(lane_count[c])
      );
   end

   // Merge lanes into the result register
   assign merge_load = (state_ff == ST_REPLY) && merge_free;

   pch_merge #(
      .MAX_CHANNELS(MAX_CHANNELS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_merge (
      .clock            (clock),
      .reset            (reset),
      .lane_count       (lane_count),
      .sel_channel      (chan_ff),
      .sel_bin          (bin_ff),
      .load             (merge_load),
      .free             (merge_free),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_count_channel(rsp_count_channel),
      .rsp_count_bin    (rsp_count_bin)
   );

endmodule

// File: hdl/pch_lane.sv
module pch_lane import pch_pkg::*; #(
   parameter int COUNT_BITS = 22
) (
   input  logic                     clock,
   input  pch_lane_ctl_type         ctl,
   input  logic [BIN_ADDR_BITS-1:0] addr,
   output logic [COUNT_BITS-1:0]    count
);

   logic [COUNT_BITS-1:0]    mem [BIN_TOTAL];
   logic [BIN_ADDR_BITS-1:0] addr_ff;
   logic [COUNT_BITS-1:0]    data_ff;
   logic                     wr_en;
   logic [BIN_ADDR_BITS-1:0] wr_addr;
   logic [COUNT_BITS-1:0]    wr_data;

   // Fetch the addressed bin when a beat is taken
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         addr_ff <= addr;
         data_ff <= mem[addr];
      end
   end

   // Single write port: clear sweep or saturating increment
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = data_ff + 1'b1;
      if (ctl.clr) begin
         wr_en   = 1'b1;
         wr_addr = ctl.clr_addr;
         wr_data = '0;
      end else if (ctl.inc && (data_ff != '1)) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign count = data_ff;

endmodule

// File: hdl/pch_merge.sv
module pch_merge import pch_pkg::*; #(
   parameter int MAX_CHANNELS = 4,
   parameter int COUNT_BITS   = 22
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [COUNT_BITS-1:0]     lane_count [MAX_CHANNELS],
   input  logic [CHAN_BITS-1:0]      sel_channel,
   input  logic [BIN_ADDR_BITS-1:0]  sel_bin,
   input  logic                      load,
   output logic                      free,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [COUNT_OUT_BITS-1:0] rsp_bin_count,
   output logic [CHAN_BITS-1:0]      rsp_count_channel,
   output logic [BIN_ADDR_BITS-1:0]  rsp_count_bin
);

   logic [COUNT_BITS-1:0]     sel;
   logic [31:0]               wide;
   logic [COUNT_OUT_BITS-1:0] capped;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_BITS-1:0] count_ff;
   logic [CHAN_BITS-1:0]      chan_ff;
   logic [BIN_ADDR_BITS-1:0]  bin_ff;

   // Pick the requested lane; a channel with no lane reads zero
   always_comb begin
      sel = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (sel_channel == CHAN_BITS'(c)) begin
            sel = lane_count[c];
         end
      end
      wide   = 32'(sel);
      capped = (wide > 32'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX : wide[COUNT_OUT_BITS-1:0];
   end

   // Output register: take a new beat once the old one is gone
   assign free         = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= capped;
         chan_ff  <= sel_channel;
         bin_ff   <= sel_bin;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_count     = count_ff;
   assign rsp_count_channel = chan_ff;
   assign rsp_count_bin     = bin_ff;

endmodule

// File: hdl/pch_checker.sv
module pch_checker import pch_pkg::*; #(
   parameter int MAX_CHANNELS = 4
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [1:0]                req_opcode,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [COUNT_OUT_BITS-1:0] rsp_bin_count,
   input logic [CHAN_BITS-1:0]      rsp_count_channel,
   input logic [BIN_ADDR_BITS-1:0]  rsp_count_bin
);

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_count)
         && $stable(rsp_count_channel) && $stable(rsp_count_bin))
      else $error("result beat changed while stalled");

   // Any real operation holds off the next request in the cycle after it is taken
   a_busy_after_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode != OP_NONE) |=> !req_ready)
      else $error("request taken while previous beat in progress");

   // Clear sweep holds off requests over its whole length, then frees them
   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_CLEAR) |-> ##256 (!req_ready ##1 req_ready))
      else $error("clear sweep length wrong");

   // Channels without a lane read back zero
   a_no_lane_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (32'(rsp_count_channel) >= MAX_CHANNELS) |-> (rsp_bin_count == '0))
      else $error("nonzero count for channel without a lane");

endmodule

bind per_channel_histogram_core pch_checker #(
   .MAX_CHANNELS(MAX_CHANNELS)
) u_pch_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_opcode       (req_opcode),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_bin_count    (rsp_bin_count),
   .rsp_count_channel(rsp_count_channel),
   .rsp_count_bin    (rsp_count_bin)
);
